// File: rtl/lmsp_pkg.sv
// Shared types, codes and width constants of the LMS linear predictor.
package lmsp_pkg;

	// Default sizes handed to the top level.
	localparam int unsigned MAX_INPUTS_DEF = 64;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Fixed field widths.
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned RATE_W    = 18;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned CFG_IDX_W = 3;

	// Function codes of an input request.
	typedef enum logic [1:0] {
		FUNC_PREDICT = 2'd0,
		FUNC_TRAIN   = 2'd1,
		FUNC_WRITE   = 2'd2,
		FUNC_READ    = 2'd3
	} func_t;

	// Kind codes of a result request.
	typedef enum logic [1:0] {
		KIND_PREDICT = 2'd0,
		KIND_TRAIN   = 2'd1,
		KIND_WEIGHT  = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARN_RATE  = 3'd0,
		CFG_INPUT_COUNT = 3'd1,
		CFG_ERROR_MEAN  = 3'd2,
		CFG_LOWER_BOUND = 3'd3,
		CFG_UPPER_BOUND = 3'd4
	} cfg_reg_t;

	// Source of the weight memory read address.
	typedef enum logic [1:0] {
		RSEL_POS  = 2'd0,
		RSEL_ITEM = 2'd1,
		RSEL_BIAS = 2'd2,
		RSEL_WALK = 2'd3
	} rsel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  item_load;
		logic  target_load;
		logic  feat_mul;
		logic  raw_load;
		logic  lim_load;
		logic  out_load;
		logic  out_weight;
		logic  train;
		logic  step_load;
		logic  walk_issue;
		logic  weight_write;
		rsel_t rd_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic idx_le_max;
		logic idx_le_n;
	} status_t;

endpackage

// File: rtl/lmsp_if.sv
// Channel interfaces of the LMS linear predictor: input, result and configuration.
interface lmsp_item_if;
	import lmsp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               func;
	logic signed [DATA_W-1:0] element_value;
	logic [COUNT_W-1:0]       weight_index;

	modport source (output valid, output func, output element_value, output weight_index,
		input ready);
	modport sink (input valid, input func, input element_value, input weight_index,
		output ready);
endinterface

interface lmsp_result_if;
	import lmsp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               kind;
	logic signed [DATA_W-1:0] raw_prediction;
	logic signed [DATA_W-1:0] corrected_prediction;
	logic signed [DATA_W-1:0] low_limit;
	logic signed [DATA_W-1:0] high_limit;
	logic                     inside_res;
	logic signed [DATA_W-1:0] prediction_error;
	logic signed [DATA_W-1:0] weight_value;

	modport source (output valid, output kind, output raw_prediction,
		output corrected_prediction, output low_limit, output high_limit,
		output inside_res, output prediction_error, output weight_value, input ready);
	modport sink (input valid, input kind, input raw_prediction,
		input corrected_prediction, input low_limit, input high_limit,
		input inside_res, input prediction_error, input weight_value, output ready);
endinterface

interface lmsp_cfg_if;
	import lmsp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/lmsp_ctrl.sv
// Controller of the LMS linear predictor: request sequencing, example position, weight walk.
module lmsp_ctrl #(
	parameter int unsigned MAX_INPUTS = lmsp_pkg::MAX_INPUTS_DEF,
	localparam int unsigned CW = $clog2(MAX_INPUTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lmsp_pkg::func_t   in_func,
	output logic              in_ready,
	input  logic [CW-1:0]     n_active,
	input  lmsp_pkg::status_t status,
	output lmsp_pkg::cmd_t    cmd,
	output logic [CW-1:0]     pos,
	output logic [CW-1:0]     walk_idx
);
	import lmsp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_READ_OUT,
		ST_FEAT,
		ST_FIN_ACC,
		ST_FIN_RAW,
		ST_FIN_LIM,
		ST_FIN_OUT,
		ST_STEP,
		ST_WALK,
		ST_DRAIN1,
		ST_DRAIN2
	} state_t;

	state_t        state_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] walk_q;
	logic          train_q;
	logic          is_example;

	assign pos        = pos_q;
	assign walk_idx   = walk_q;
	assign is_example = in_func inside {FUNC_PREDICT, FUNC_TRAIN};

	// Commands decoded from the current state.
	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RSEL_POS;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// The weight at the current position is read ahead of the next feature.
				in_ready          = 1'b1;
				cmd.item_load     = in_valid;
				cmd.target_load   = in_valid && is_example && (pos_q == '0);
			end
			ST_WRITE: begin
				cmd.weight_write = status.idx_le_max;
			end
			ST_READ: begin
				cmd.rd_sel = RSEL_ITEM;
			end
			ST_READ_OUT: begin
				cmd.rd_sel     = RSEL_ITEM;
				cmd.out_load   = status.out_free;
				cmd.out_weight = 1'b1;
			end
			ST_FEAT: begin
				cmd.feat_mul = 1'b1;
			end
			ST_FIN_ACC: begin
				cmd.rd_sel = RSEL_BIAS;
			end
			ST_FIN_RAW: begin
				cmd.raw_load = 1'b1;
			end
			ST_FIN_LIM: begin
				cmd.lim_load = 1'b1;
			end
			ST_FIN_OUT: begin
				cmd.out_load = status.out_free;
				cmd.train    = train_q;
			end
			ST_STEP: begin
				cmd.step_load = 1'b1;
			end
			ST_WALK: begin
				cmd.rd_sel     = RSEL_WALK;
				cmd.walk_issue = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// State, example position and walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			walk_q  <= '0;
			train_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (in_func)
							FUNC_WRITE: state_q <= ST_WRITE;
							FUNC_READ:  state_q <= ST_READ;
							default: begin
								train_q <= (in_func == FUNC_TRAIN);
								if (pos_q != '0) begin
									state_q <= ST_FEAT;
								end else if (n_active == '0) begin
									state_q <= ST_FIN_ACC;
								end else begin
									pos_q <= CW'(1);
								end
							end
						endcase
					end
				end
				ST_WRITE: state_q <= ST_IDLE;
				ST_READ:  state_q <= ST_READ_OUT;
				ST_READ_OUT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FEAT: begin
					// The example completes once the position reaches the active count.
					if (pos_q >= n_active) begin
						pos_q   <= '0;
						state_q <= ST_FIN_ACC;
					end else begin
						pos_q   <= pos_q + CW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_FIN_ACC: state_q <= ST_FIN_RAW;
				ST_FIN_RAW: state_q <= ST_FIN_LIM;
				ST_FIN_LIM: state_q <= ST_FIN_OUT;
				ST_FIN_OUT: begin
					if (status.out_free) begin
						state_q <= train_q ? ST_STEP : ST_IDLE;
					end
				end
				ST_STEP: begin
					walk_q  <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					// Bias and every active weight are issued once, one per cycle.
					if (walk_q == n_active) begin
						state_q <= ST_DRAIN1;
					end else begin
						walk_q <= walk_q + CW'(1);
					end
				end
				ST_DRAIN1: state_q <= ST_DRAIN2;
				ST_DRAIN2: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// The position never runs past the last feature slot.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= (CW + 1)'(MAX_INPUTS))
		else $error("example position beyond feature store");

	// Weights are walked only after a training example.
	a_walk_train: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_issue |-> train_q)
		else $error("weight walk outside training");

endmodule

// File: rtl/lmsp_dp.sv
// Datapath of the LMS linear predictor: config, weight and feature memories, MAC, update.
module lmsp_dp #(
	parameter int unsigned MAX_INPUTS = lmsp_pkg::MAX_INPUTS_DEF,
	parameter int unsigned FRAC_BITS  = lmsp_pkg::FRAC_BITS_DEF,
	localparam int unsigned CW = $clog2(MAX_INPUTS + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [lmsp_pkg::DATA_W-1:0] element_value,
	input  logic [lmsp_pkg::COUNT_W-1:0]       weight_index,
	input  lmsp_pkg::cmd_t                     cmd,
	output lmsp_pkg::status_t                  status,
	output logic [CW-1:0]                      n_active,
	input  logic [CW-1:0]                      pos,
	input  logic [CW-1:0]                      walk_idx,
	lmsp_result_if.source                      result,
	lmsp_cfg_if.sink                           cfg
);
	import lmsp_pkg::*;

	localparam int unsigned WIDE_W = 2 * DATA_W + 2;
	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned SUM_W  = PROD_W + 1;
	localparam int unsigned STEP_W = RATE_W + DATA_W + 1;
	localparam int unsigned CMP_W  = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int unsigned FW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
	localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_INPUTS);
	localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'sd1 << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
	localparam logic signed [PROD_W-1:0] ACC_MAX = {1'b0, {(PROD_W - 1){1'b1}}};
	localparam logic signed [PROD_W-1:0] ACC_MIN = {1'b1, {(PROD_W - 1){1'b0}}};

	// Clamp a wide signed value to the signed data range.
	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-DATA_W:0] top;
		top = v[WIDE_W-1:DATA_W-1];
		if (top == {(WIDE_W - DATA_W + 1){v[WIDE_W-1]}}) begin
			return v[DATA_W-1:0];
		end
		return v[WIDE_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	// Configuration registers.
	logic [RATE_W-1:0]        rate_q;
	logic [COUNT_W-1:0]       count_q;
	logic signed [DATA_W-1:0] mean_q;
	logic signed [DATA_W-1:0] lowb_q;
	logic signed [DATA_W-1:0] upb_q;

	// Item, example and result registers.
	logic signed [DATA_W-1:0] val_q;
	logic [COUNT_W-1:0]       idx_q;
	logic signed [DATA_W-1:0] target_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [DATA_W-1:0] raw_q;
	logic signed [DATA_W-1:0] corr_q;
	logic signed [DATA_W-1:0] lo_q;
	logic signed [DATA_W-1:0] hi_q;
	logic signed [DATA_W-1:0] err_q;
	logic signed [DATA_W-1:0] step_q;

	// Memories and their read registers.
	logic signed [DATA_W-1:0] weight_mem [MAX_INPUTS + 1];
	logic signed [DATA_W-1:0] feat_mem [MAX_INPUTS];
	logic signed [DATA_W-1:0] w_rdata;
	logic signed [DATA_W-1:0] x_rdata;

	// Multiply and update pipeline.
	logic                     vld_s1;
	logic [CW-1:0]            idx_s1;
	logic                     vld_s2;
	logic                     acc_pend_s2;
	logic [CW-1:0]            idx_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DATA_W-1:0] w_s2;

	// Output register.
	logic                     out_vld_q;
	kind_t                    out_kind_q;
	logic signed [DATA_W-1:0] out_raw_q;
	logic signed [DATA_W-1:0] out_corr_q;
	logic signed [DATA_W-1:0] out_lo_q;
	logic signed [DATA_W-1:0] out_hi_q;
	logic                     out_inside_q;
	logic signed [DATA_W-1:0] out_err_q;
	logic signed [DATA_W-1:0] out_weight_q;

	logic [CMP_W-1:0]         count_ext;
	logic [CMP_W-1:0]         n_ext;
	logic [CMP_W-1:0]         idx_ext;
	logic [CW-1:0]            item_addr;
	logic [CW-1:0]            rd_addr;
	logic [FW-1:0]            feat_wr_addr;
	logic [FW-1:0]            feat_rd_addr;
	logic                     wr_en;
	logic [CW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic signed [DATA_W-1:0] new_w;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [PROD_W-1:0] acc_next;
	logic signed [STEP_W-1:0] step_prod;
	logic                     in_range;

	// Configuration writes, accepted in any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= '0;
			count_q <= '0;
			mean_q  <= '0;
			lowb_q  <= '0;
			upb_q   <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				CFG_LEARN_RATE:  rate_q  <= cfg.data[RATE_W-1:0];
				CFG_INPUT_COUNT: count_q <= cfg.data[COUNT_W-1:0];
				CFG_ERROR_MEAN:  mean_q  <= $signed(cfg.data);
				CFG_LOWER_BOUND: lowb_q  <= $signed(cfg.data);
				CFG_UPPER_BOUND: upb_q   <= $signed(cfg.data);
				default: begin
				end
			endcase
		end
	end

	// Active feature count and index range checks.
	assign count_ext = CMP_W'(count_q);
	assign n_ext     = (count_ext > MAX_EXT) ? MAX_EXT : count_ext;
	assign n_active  = CW'(n_ext);
	assign idx_ext   = CMP_W'(idx_q);
	assign item_addr = CW'(idx_q);

	assign status.idx_le_max = (idx_ext <= MAX_EXT);
	assign status.idx_le_n   = (idx_ext <= n_ext);
	assign status.out_free   = !out_vld_q || result.ready;

	// Latch the request payload and the target of a new example.
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			val_q <= element_value;
			idx_q <= weight_index;
		end
		if (cmd.target_load) begin
			target_q <= element_value;
		end
	end

	// Weight memory: one write port shared by weight writes and the walk, one read port.
	always_comb begin
		case (cmd.rd_sel)
			RSEL_POS:  rd_addr = pos;
			RSEL_ITEM: rd_addr = item_addr;
			RSEL_BIAS: rd_addr = '0;
			RSEL_WALK: rd_addr = walk_idx;
			default:   rd_addr = pos;
		endcase
	end

	assign new_w   = sat_data(WIDE_W'(w_s2) - WIDE_W'(prod_s2 >>> FRAC_BITS));
	assign wr_en   = vld_s2 || cmd.weight_write;
	assign wr_addr = vld_s2 ? idx_s2 : item_addr;
	assign wr_data = vld_s2 ? new_w : val_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			weight_mem[wr_addr] <= wr_data;
		end
		w_rdata <= weight_mem[rd_addr];
	end

	// Feature memory: written per feature, read during the walk.
	assign feat_wr_addr = FW'(pos - CW'(1));
	assign feat_rd_addr = FW'(walk_idx - CW'(1));

	always_ff @(posedge clk) begin
		if (cmd.feat_mul) begin
			feat_mem[feat_wr_addr] <= val_q;
		end
		x_rdata <= feat_mem[feat_rd_addr];
	end

	// Shared multiplier: weight times feature, or during the walk step times feature (one for the bias).
	assign mul_a = vld_s1 ? step_q : w_rdata;
	assign mul_b = vld_s1 ? ((idx_s1 == '0) ? ONE_Q : x_rdata) : val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			acc_pend_s2 <= 1'b0;
		end else begin
			vld_s1      <= cmd.walk_issue;
			vld_s2      <= vld_s1;
			acc_pend_s2 <= cmd.feat_mul;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= walk_idx;
		idx_s2 <= idx_s1;
		w_s2   <= w_rdata;
		if (vld_s1 || cmd.feat_mul) begin
			prod_s2 <= mul_a * mul_b;
		end
	end

	// Saturating dot-product accumulator.
	assign acc_sum  = SUM_W'(acc_q) + SUM_W'(prod_s2);
	assign acc_next = (acc_sum[SUM_W-1] != acc_sum[SUM_W-2]) ?
		(acc_sum[SUM_W-1] ? ACC_MIN : ACC_MAX) : acc_sum[PROD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.target_load) begin
			acc_q <= '0;
		end else if (acc_pend_s2) begin
			acc_q <= acc_next;
		end
	end

	// Prediction, then limits and error together, then update step, each in one register stage.
	assign step_prod = $signed({1'b0, rate_q}) * err_q;

	always_ff @(posedge clk) begin
		if (cmd.raw_load) begin
			raw_q <= sat_data(WIDE_W'(w_rdata) + WIDE_W'(acc_q >>> FRAC_BITS));
		end
		if (cmd.lim_load) begin
			corr_q <= sat_data(WIDE_W'(raw_q) - WIDE_W'(mean_q));
			lo_q   <= sat_data(WIDE_W'(raw_q) - WIDE_W'(upb_q));
			hi_q   <= sat_data(WIDE_W'(raw_q) - WIDE_W'(lowb_q));
			err_q  <= sat_data(WIDE_W'(raw_q) - WIDE_W'(target_q));
		end
		if (cmd.step_load) begin
			step_q <= sat_data(WIDE_W'(step_prod >>> FRAC_BITS));
		end
	end

	// Output register; it holds its request until the receiver takes it.
	assign in_range = (lo_q <= target_q) && (target_q <= hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_weight) begin
				out_kind_q   <= KIND_WEIGHT;
				out_raw_q    <= '0;
				out_corr_q   <= '0;
				out_lo_q     <= '0;
				out_hi_q     <= '0;
				out_inside_q <= 1'b0;
				out_err_q    <= '0;
				out_weight_q <= status.idx_le_n ? w_rdata : '0;
			end else begin
				out_kind_q   <= cmd.train ? KIND_TRAIN : KIND_PREDICT;
				out_raw_q    <= raw_q;
				out_corr_q   <= corr_q;
				out_lo_q     <= lo_q;
				out_hi_q     <= hi_q;
				out_inside_q <= in_range;
				out_err_q    <= err_q;
				out_weight_q <= '0;
			end
		end
	end

	assign result.valid                = out_vld_q;
	assign result.kind                 = out_kind_q;
	assign result.raw_prediction       = out_raw_q;
	assign result.corrected_prediction = out_corr_q;
	assign result.low_limit            = out_lo_q;
	assign result.high_limit           = out_hi_q;
	assign result.inside_res           = out_inside_q;
	assign result.prediction_error     = out_err_q;
	assign result.weight_value         = out_weight_q;

	// A pending result is never overwritten.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || result.ready))
		else $error("output register overwritten while pending");

	// A new example never starts while a product is still being added.
	a_acc_order: assert property (@(posedge clk) disable iff (!arst_n)
		acc_pend_s2 |-> !cmd.target_load)
		else $error("accumulator cleared with a product pending");

	// Walk write-back and request weight writes never share the write port.
	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !cmd.weight_write)
		else $error("weight write port collision");

endmodule

// File: rtl/lms_linear_predictor.sv
// Top level of the LMS linear predictor: controller and datapath joined by command and status.
//
// Usage: each example is sent on the item channel as requests of function predict or
// train: the target first, then input_count features. The function of the request that
// completes an example selects prediction or training. Write and read requests access
// single weights (index 0 is the bias) at any time, also in the middle of an example.
// Registers are written on the cfg channel (always ready) while the block is idle: the user
// must keep to this, the block does not enforce it. A target that does not complete an
// example is taken in the idle state; a feature is taken there with its weight read ahead,
// then goes through one shared 32x32 multiplier (the add into the 64-bit accumulator
// overlaps the next request). A completed example then reads the bias, forms the raw
// prediction, then limits and error, and loads the output register. Training then walks the
// bias and every active weight through the same multiplier, one per cycle, and drains the
// updates. A weight write or read takes its own state; a read loads the output register.
// The result sits in an output register; while the receiver stalls, further requests
// are accepted until the next result is due, which then waits for the register.
// Reset clears configuration, position and handshake state at once; the weight and
// feature memories are not cleared and hold undefined values until written.
module lms_linear_predictor #(
	parameter int unsigned MAX_INPUTS = lmsp_pkg::MAX_INPUTS_DEF,
	parameter int unsigned FRAC_BITS  = lmsp_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lmsp_item_if.sink     item,
	lmsp_result_if.source result,
	lmsp_cfg_if.sink      cfg
);
	import lmsp_pkg::*;

	localparam int unsigned CW = $clog2(MAX_INPUTS + 1);

	cmd_t          cmd;
	status_t       status;
	logic [CW-1:0] n_active;
	logic [CW-1:0] pos;
	logic [CW-1:0] walk_idx;
	logic          in_ready;

	assign item.ready = in_ready;

	// Sequencing of requests, example position and weight walk.
	lmsp_ctrl #(
		.MAX_INPUTS (MAX_INPUTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_func  (func_t'(item.func)),
		.in_ready (in_ready),
		.n_active (n_active),
		.status   (status),
		.cmd      (cmd),
		.pos      (pos),
		.walk_idx (walk_idx)
	);

	// Memories, arithmetic and output register.
	lmsp_dp #(
		.MAX_INPUTS (MAX_INPUTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_value (item.element_value),
		.weight_index  (item.weight_index),
		.cmd           (cmd),
		.status        (status),
		.n_active      (n_active),
		.pos           (pos),
		.walk_idx      (walk_idx),
		.result        (result),
		.cfg           (cfg)
	);

endmodule
